### design/drfp_pkg.sv
// ----------------------------------------------------------------------------
// drfp_pkg: shared types and constants of the display reply frame parser
// Frame geometry, command codes, register indexes and the job descriptor
// passed from the front to the back.
// ----------------------------------------------------------------------------
package drfp_pkg;

  // Frame buffer geometry
  localparam int unsigned FRAME_BYTES = 64;
  localparam int unsigned ADDR_W      = $clog2(FRAME_BYTES);
  localparam int unsigned HDR_AND_LEN = 3;
  // Largest body length that still fits the buffer
  localparam logic [7:0]  MAX_LEN     = 8'(FRAME_BYTES - HDR_AND_LEN);

  // Byte positions inside a frame
  localparam logic [ADDR_W-1:0] POS_CMD     = ADDR_W'(3);
  localparam logic [ADDR_W-1:0] POS_ADDR_HI = ADDR_W'(4);
  localparam logic [ADDR_W-1:0] POS_ADDR_LO = ADDR_W'(5);
  localparam logic [ADDR_W-1:0] POS_B6      = ADDR_W'(6);
  localparam logic [ADDR_W-1:0] POS_B7      = ADDR_W'(7);
  localparam logic [ADDR_W-1:0] POS_B8      = ADDR_W'(8);

  // Last byte index thresholds (last index = frame size - 1)
  localparam logic [ADDR_W-1:0] VAR_MIN_LAST = ADDR_W'(7);  // size 8
  localparam logic [ADDR_W-1:0] VAR_KEY_LAST = ADDR_W'(8);  // size 9
  localparam logic [ADDR_W-1:0] CLK_MIN_LAST = ADDR_W'(4);  // size 5
  localparam logic [ADDR_W-1:0] FIRST_PAYLOAD = ADDR_W'(4);

  // Command codes
  localparam logic [7:0] CMD_VAR_REPORT = 8'h83;
  localparam logic [7:0] CMD_CLOCK_DATA = 8'h81;

  // Configuration registers
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_SECOND = 1'b1;
  localparam logic [7:0] HDR_FIRST_RST  = 8'h5A;
  localparam logic [7:0] HDR_SECOND_RST = 8'hA5;

  // Job queue
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Job kind doubles as the result event kind
  typedef enum logic [1:0] {
    JOB_VAR     = 2'd0,
    JOB_VAR_KEY = 2'd1,
    JOB_CLOCK   = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [15:0]       var_address;
    logic [7:0]        key_id;
    logic [15:0]       var_value;
    logic [ADDR_W-1:0] last_idx;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef enum logic [1:0] {
    FS_HUNT,
    FS_HDR2,
    FS_LEN,
    FS_BODY
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_READ,
    BS_LOAD,
    BS_WAIT
  } back_state_t;

endpackage

### design/drfp_front.sv
// ----------------------------------------------------------------------------
// drfp_front: header hunt and frame collection
// Accepts received bytes, writes the body into the frame buffer and turns
// each completed frame with a known command and enough bytes into a job descriptor.
// ----------------------------------------------------------------------------
module drfp_front import drfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  logic                 q_full,
  output logic                 push,
  output job_t                 push_job,
  input  logic                 clk_done,
  output mem_wr_t              mem_wr
);

  front_state_t      state_r, state_nxt;
  logic [7:0]        hdr_first_r, hdr_second_r;
  logic [ADDR_W-1:0] fill_r;
  logic [7:0]        len_r;
  logic [7:0]        cmd_r, b4_r, b5_r, b6_r, b7_r, b8_r;
  logic              clk_pend_r;

  logic              accept;
  logic              in_body;
  logic              done;
  logic [7:0]        cmd_c, b4_c, b5_c, b6_c, b7_c, b8_c;
  logic              job_ok;

  assign in_ready = !q_full && !clk_pend_r;
  assign accept   = in_valid && in_ready;
  assign in_body  = (state_r == FS_BODY);
  assign done     = in_body && ({{(8-ADDR_W){1'b0}}, fill_r} == len_r + 8'd2);

  // Current byte merged over the captured ones
  assign cmd_c = (fill_r == POS_CMD)     ? in_rx_byte : cmd_r;
  assign b4_c  = (fill_r == POS_ADDR_HI) ? in_rx_byte : b4_r;
  assign b5_c  = (fill_r == POS_ADDR_LO) ? in_rx_byte : b5_r;
  assign b6_c  = (fill_r == POS_B6)      ? in_rx_byte : b6_r;
  assign b7_c  = (fill_r == POS_B7)      ? in_rx_byte : b7_r;
  assign b8_c  = (fill_r == POS_B8)      ? in_rx_byte : b8_r;

  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      unique case (state_r)
        FS_HUNT: state_nxt = (in_rx_byte == hdr_first_r) ? FS_HDR2 : FS_HUNT;
        FS_HDR2: state_nxt = (in_rx_byte == hdr_second_r) ? FS_LEN : FS_HUNT;
        FS_LEN: begin
          // drop oversized frames and frames with an empty body
          if (in_rx_byte > MAX_LEN || in_rx_byte == 8'd0) begin
            state_nxt = FS_HUNT;
          end else begin
            state_nxt = FS_BODY;
          end
        end
        FS_BODY: state_nxt = done ? FS_HUNT : FS_BODY;
        default: state_nxt = FS_HUNT;
      endcase
    end
  end

  always_comb begin
    job_ok            = 1'b0;
    push_job          = '0;
    push_job.last_idx = fill_r;
    push_job.kind     = JOB_VAR;
    if (cmd_c == CMD_VAR_REPORT && fill_r >= VAR_MIN_LAST) begin
      job_ok               = 1'b1;
      push_job.var_address = {b4_c, b5_c};
      if (fill_r == VAR_KEY_LAST) begin
        push_job.kind      = JOB_VAR_KEY;
        push_job.key_id    = b6_c;
        push_job.var_value = {b7_c, b8_c};
      end else begin
        push_job.var_value = {b6_c, b7_c};
      end
    end else if (cmd_c == CMD_CLOCK_DATA && fill_r >= CLK_MIN_LAST) begin
      job_ok        = 1'b1;
      push_job.kind = JOB_CLOCK;
    end
    push        = accept && done && job_ok;
    mem_wr.en   = accept && in_body;
    mem_wr.addr = fill_r;
    mem_wr.data = in_rx_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FS_HUNT;
      hdr_first_r  <= HDR_FIRST_RST;
      hdr_second_r <= HDR_SECOND_RST;
      fill_r       <= '0;
      len_r        <= '0;
      clk_pend_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HDR_FIRST:  hdr_first_r  <= cfg_data;
          CFG_HDR_SECOND: hdr_second_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept && state_r == FS_LEN) begin
        len_r  <= in_rx_byte;
        fill_r <= POS_CMD;
      end else if (accept && in_body) begin
        fill_r <= fill_r + ADDR_W'(1);
      end
      // hold off new bytes while a clock job still reads the buffer
      if (push && push_job.kind == JOB_CLOCK) begin
        clk_pend_r <= 1'b1;
      end else if (clk_done) begin
        clk_pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_body) begin
      cmd_r <= cmd_c;
      b4_r  <= b4_c;
      b5_r  <= b5_c;
      b6_r  <= b6_c;
      b7_r  <= b7_c;
      b8_r  <= b8_c;
    end
  end

endmodule

### design/drfp_queue.sv
// ----------------------------------------------------------------------------
// drfp_queue: job queue between front and back
// Small register queue of job descriptors.
// ----------------------------------------------------------------------------
module drfp_queue import drfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head_job
);

  job_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  assign full     = (count_r == Q_CNT_W'(Q_DEPTH));
  assign valid    = (count_r != '0);
  assign head_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### design/drfp_back.sv
// ----------------------------------------------------------------------------
// drfp_back: frame buffer and result sequencer
// Holds the frame buffer and turns each job into one or more results.
// ----------------------------------------------------------------------------
module drfp_back import drfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mem_wr_t     mem_wr,
  input  logic        q_valid,
  input  job_t        q_job,
  output logic        q_pop,
  output logic        clk_done,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_kind,
  output logic [15:0] out_var_address,
  output logic [7:0]  out_key_id,
  output logic [15:0] out_var_value,
  output logic [7:0]  out_clock_byte,
  output logic        out_last
);

  logic [7:0]        mem [FRAME_BYTES];
  logic [7:0]        rd_data_r;

  back_state_t       state_r, state_nxt;
  job_t              job_r;
  logic [ADDR_W-1:0] idx_r;
  logic [1:0]        kind_r;
  logic [15:0]       addr_r, value_r;
  logic [7:0]        key_r, clock_r;
  logic              last_r;

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
    rd_data_r <= mem[idx_r];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_job.kind == JOB_CLOCK) ? BS_READ : BS_WAIT;
        end
      end
      BS_READ: state_nxt = BS_LOAD;
      BS_LOAD: state_nxt = BS_WAIT;
      BS_WAIT: begin
        if (out_ready) begin
          state_nxt = last_r ? BS_IDLE : BS_READ;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == BS_IDLE) && q_valid;
    out_valid = (state_r == BS_WAIT);
    clk_done  = out_valid && out_ready && last_r && (job_r.kind == JOB_CLOCK);
  end

  assign out_event_kind  = kind_r;
  assign out_var_address = addr_r;
  assign out_key_id      = key_r;
  assign out_var_value   = value_r;
  assign out_clock_byte  = clock_r;
  assign out_last        = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BS_IDLE: begin
        if (q_valid) begin
          job_r   <= q_job;
          idx_r   <= FIRST_PAYLOAD;
          kind_r  <= q_job.kind;
          addr_r  <= q_job.var_address;
          key_r   <= q_job.key_id;
          value_r <= q_job.var_value;
          clock_r <= '0;
          last_r  <= 1'b1;
        end
      end
      BS_READ: ;
      BS_LOAD: begin
        kind_r  <= JOB_CLOCK;
        addr_r  <= '0;
        key_r   <= '0;
        value_r <= '0;
        clock_r <= rd_data_r;
        last_r  <= (idx_r == job_r.last_idx);
      end
      BS_WAIT: begin
        if (out_ready && !last_r) begin
          idx_r <= idx_r + ADDR_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

### design/display_reply_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// display_reply_frame_parser_unit: serial reply frame parser
// A variable report's job passes the job queue into the back end's output
//   registers; a clock data job reads each payload byte through READ and LOAD.
// Throughput: one byte per cycle while the job queue has room; input stalls
//   until a clock frame's last result is taken.
// Reset: synchronous active-low rst_n restores the default header bytes
//   and returns to the header hunt; the frame buffer is not cleared.
// ----------------------------------------------------------------------------
module display_reply_frame_parser_unit import drfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  // received byte channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_event_kind,
  output logic [15:0]          out_var_address,
  output logic [7:0]           out_key_id,
  output logic [15:0]          out_var_value,
  output logic [7:0]           out_clock_byte,
  output logic                 out_last
);

  // Front to queue
  logic    push;
  job_t    push_job;
  logic    q_full;
  // Queue to back
  logic    q_valid;
  job_t    q_job;
  logic    q_pop;
  // Back to front: a clock job has released the frame buffer
  logic    clk_done;
  mem_wr_t mem_wr;

  // Front: hunt for the header, collect the body, build at most one job per frame.
  // It stalls its input while a clock data job still owns the buffer, since
  // the next frame would overwrite the payload being streamed out.
  drfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job),
    .clk_done   (clk_done),
    .mem_wr     (mem_wr)
  );

  // Queue: decouple frame collection from result delivery.
  drfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_job (q_job)
  );

  // Back: hold each result in an output register until the transaction
  // completes; clock data bytes are read out of the buffer one at a time.
  drfp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .mem_wr          (mem_wr),
    .q_valid         (q_valid),
    .q_job           (q_job),
    .q_pop           (q_pop),
    .clk_done        (clk_done),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_var_address (out_var_address),
    .out_key_id      (out_key_id),
    .out_var_value   (out_var_value),
    .out_clock_byte  (out_clock_byte),
    .out_last        (out_last)
  );

endmodule

### tb/drfp_tb_pkg.sv
// ----------------------------------------------------------------------------
// drfp_tb_pkg: reply prediction and checking for the frame parser bench
// Tracks header hunt and frame assembly byte by byte, decodes each
// completed frame into the replies it must produce, and compares them in
// order with what the parser delivers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package drfp_tb_pkg;
  import drfp_pkg::*;

  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] var_address;
    logic [7:0]  key_id;
    logic [15:0] var_value;
    logic [7:0]  clock_byte;
    logic        last;
  } reply_t;

  class reply_scoreboard;
    logic [7:0]  frame_buf [FRAME_BYTES];
    int unsigned held;
    bit          collecting;
    logic [7:0]  hdr_first;
    logic [7:0]  hdr_second;
    reply_t      expected_q [$];
    int unsigned bytes_seen;
    int unsigned replies_expected;
    int unsigned replies_checked;
    int unsigned frames_replied;
    int unsigned errors;

    function new();
      foreach (frame_buf[i]) frame_buf[i] = 8'h00;
      held             = 0;
      collecting       = 1'b0;
      hdr_first        = HDR_FIRST_RST;
      hdr_second       = HDR_SECOND_RST;
      bytes_seen       = 0;
      replies_expected = 0;
      replies_checked  = 0;
      frames_replied   = 0;
      errors           = 0;
    endfunction

    function void write_header(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      if (idx == CFG_HDR_FIRST) hdr_first = val;
      else if (idx == CFG_HDR_SECOND) hdr_second = val;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void push_reply(job_kind_t k, logic [15:0] addr, logic [7:0] key,
                             logic [15:0] val, logic [7:0] cb, logic lst);
      reply_t r;
      r.kind        = k;
      r.var_address = addr;
      r.key_id      = key;
      r.var_value   = val;
      r.clock_byte  = cb;
      r.last        = lst;
      expected_q.push_back(r);
      replies_expected++;
    endfunction

    // Turn a complete frame of n bytes into its replies
    function void decode_frame(int unsigned n);
      logic [15:0] addr;
      int unsigned before_cnt;
      addr       = {frame_buf[4], frame_buf[5]};
      before_cnt = replies_expected;
      if (n < 4 || n > FRAME_BYTES) return;
      if (frame_buf[3] == CMD_VAR_REPORT) begin
        if (n < 8) return;
        if (n == 9)
          push_reply(JOB_VAR_KEY, addr, frame_buf[6], {frame_buf[7], frame_buf[8]},
                     8'h00, 1'b1);
        else
          push_reply(JOB_VAR, addr, 8'h00, {frame_buf[6], frame_buf[7]}, 8'h00, 1'b1);
      end else if (frame_buf[3] == CMD_CLOCK_DATA && n >= 5) begin
        for (int unsigned i = 4; i < n; i++)
          push_reply(JOB_CLOCK, 16'h0000, 8'h00, 16'h0000, frame_buf[i], (i + 1) == n);
      end
      if (replies_expected != before_cnt) frames_replied++;
    endfunction

    // Advance the hunt / assembly by one accepted byte
    function void note_byte(logic [7:0] b);
      int unsigned total;
      bytes_seen++;
      if (!collecting) begin
        if (held == 0 && b == hdr_first) begin
          frame_buf[0] = b;
          held = 1;
        end else if (held == 1 && b == hdr_second) begin
          frame_buf[1] = b;
          held = 2;
          collecting = 1'b1;
        end else begin
          held = 0;
        end
        return;
      end
      if (held >= FRAME_BYTES) begin
        held = 0;
        collecting = 1'b0;
        return;
      end
      frame_buf[held] = b;
      held++;
      if (held < HDR_AND_LEN) return;
      total = int'(frame_buf[2]) + HDR_AND_LEN;
      // drop oversized frames, compared at full width
      if (held == HDR_AND_LEN && total > FRAME_BYTES) begin
        held = 0;
        collecting = 1'b0;
        return;
      end
      if (held >= total) begin
        decode_frame(held);
        held = 0;
        collecting = 1'b0;
      end
    endfunction

    function void report_field(string name, logic [15:0] want, logic [15:0] got);
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected reply: expected none, actual kind=%0d addr=%h key=%h",
                 $time, got.kind, got.var_address, got.key_id);
        $display("%0t:   value=%h clock=%h last=%b", $time, got.var_value, got.clock_byte,
                 got.last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      replies_checked++;
      if (got.kind !== want.kind) report_field("event_kind", want.kind, got.kind);
      if (got.var_address !== want.var_address)
        report_field("var_address", want.var_address, got.var_address);
      if (got.key_id !== want.key_id) report_field("key_id", want.key_id, got.key_id);
      if (got.var_value !== want.var_value)
        report_field("var_value", want.var_value, got.var_value);
      if (got.clock_byte !== want.clock_byte)
        report_field("clock_byte", want.clock_byte, got.clock_byte);
      if (got.last !== want.last) report_field("last", want.last, got.last);
    endfunction
  endclass

endpackage

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: bench for the display reply frame parser unit
// Feeds directed frames and then mostly well-formed random frames mixed
// with noise and broken headers, under several header settings and idle
// patterns, and checks every reply against a byte-level prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top import drfp_pkg::*, drfp_tb_pkg::*; ();

  // Worst case: a few hundred bytes, each able to end a 60-reply frame,
  // every reply stalled by the receiver; taken with a wide margin.
  localparam int unsigned CYCLE_LIMIT   = 400000;
  // Cycles to let the back end finish after the last expected reply
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef logic [7:0] byte_seq_t [$];

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_HDR_FIRST;
  logic [7:0]           cfg_data   = 8'h00;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [1:0]           out_event_kind;
  logic [15:0]          out_var_address;
  logic [7:0]           out_key_id;
  logic [15:0]          out_var_value;
  logic [7:0]           out_clock_byte;
  logic                 out_last;

  // Idle percentages of the sender and the receiver
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycles        = 0;
  int unsigned settings_used = 1;

  // Header bytes currently programmed, used to build frames
  logic [7:0] cur_first  = HDR_FIRST_RST;
  logic [7:0] cur_second = HDR_SECOND_RST;

  reply_scoreboard sb;
  reply_t          seen_reply;

  display_reply_frame_parser_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_var_address (out_var_address),
    .out_key_id      (out_key_id),
    .out_var_value   (out_var_value),
    .out_clock_byte  (out_clock_byte),
    .out_last        (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: decide readiness at each falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result monitor: check each reply transaction at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_reply.kind        = job_kind_t'(out_event_kind);
      seen_reply.var_address = out_var_address;
      seen_reply.key_id      = out_key_id;
      seen_reply.var_value   = out_var_value;
      seen_reply.clock_byte  = out_clock_byte;
      seen_reply.last        = out_last;
      sb.check_reply(seen_reply);
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles with %0d replies outstanding",
               $time, CYCLE_LIMIT, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Present one byte, idling at random first, and hold it until the
  // transaction completes; then hand it to the predictor.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
  endtask

  task automatic send_seq(input byte_seq_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Drop valid and hold off until every expected reply has arrived
  task automatic wait_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Reprogram both header bytes with the parser idle
  task automatic set_headers(input logic [7:0] first, input logic [7:0] second);
    wait_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HDR_FIRST;
    cfg_data  <= first;
    @(negedge clk);
    cfg_index <= CFG_HDR_SECOND;
    cfg_data  <= second;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_header(CFG_HDR_FIRST, first);
    sb.write_header(CFG_HDR_SECOND, second);
    cur_first  = first;
    cur_second = second;
    settings_used++;
  endtask

  // One random chunk: mostly well-formed frames, the rest noise, broken
  // headers, oversized lengths and truncated frames.
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  cmd;
    byte_seq_t   seq;
    pick = $urandom_range(99);
    if (pick < 72) begin
      case ($urandom_range(9))
        0, 1, 2, 3: cmd = CMD_VAR_REPORT;
        4, 5, 6, 7: cmd = CMD_CLOCK_DATA;
        default:    cmd = 8'($urandom_range(255));
      endcase
      if (cmd == CMD_VAR_REPORT) begin
        case ($urandom_range(4))
          0:       len = 5;
          1:       len = 6;
          2:       len = $urandom_range(4);
          default: len = $urandom_range(20, 7);
        endcase
      end else if (cmd == CMD_CLOCK_DATA) begin
        // keep the full-buffer frame rare
        len = ($urandom_range(15) == 0) ? int'(MAX_LEN) : $urandom_range(10);
      end else begin
        len = $urandom_range(8);
      end
      seq = '{cur_first, cur_second, 8'(len)};
      if (len > 0) seq.push_back(cmd);
      for (int unsigned i = 1; i < len; i++) seq.push_back(8'($urandom_range(255)));
    end else if (pick < 80) begin
      len = $urandom_range(4, 1);
      for (int unsigned i = 0; i < len; i++) seq.push_back(8'($urandom_range(255)));
    end else if (pick < 88) begin
      case ($urandom_range(2))
        0:       seq = '{cur_first, 8'($urandom_range(255))};
        1:       seq = '{cur_first, cur_first, cur_second};  // repeated first byte
        default: seq = '{cur_second, cur_first};
      endcase
    end else if (pick < 94) begin
      seq = '{cur_first, cur_second, 8'($urandom_range(255, int'(MAX_LEN) + 1))};
    end else begin
      // frame cut short: the following bytes land in its body
      len = $urandom_range(20, 6);
      seq = '{cur_first, cur_second, 8'(len), CMD_CLOCK_DATA};
      for (int unsigned i = 0; i < len / 2; i++) seq.push_back(8'($urandom_range(255)));
    end
    send_seq(seq);
  endtask

  task automatic run_random(input int unsigned min_bytes, input int unsigned min_replies);
    int unsigned start;
    start = sb.bytes_seen;
    while (sb.bytes_seen - start < min_bytes || sb.replies_expected < min_replies) begin
      send_random_frame();
      // now and then hold the sender until the parser has drained
      if ($urandom_range(11) == 0) wait_replies();
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 28;
    recv_idle_pct = 61;

    // Directed: no resync on a repeated first byte, then each decode
    // path at field extremes, empty body and the smallest oversize length.
    send_seq('{HDR_FIRST_RST, HDR_FIRST_RST, HDR_SECOND_RST});
    send_seq('{HDR_FIRST_RST, HDR_SECOND_RST, 8'd6, CMD_VAR_REPORT,
               8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF});
    send_seq('{HDR_FIRST_RST, HDR_SECOND_RST, 8'd5, CMD_VAR_REPORT,
               8'h00, 8'h00, 8'h00, 8'h00});
    send_seq('{HDR_FIRST_RST, HDR_SECOND_RST, 8'd2, CMD_CLOCK_DATA, 8'hFF});
    send_seq('{HDR_FIRST_RST, HDR_SECOND_RST, 8'd0});
    send_seq('{HDR_FIRST_RST, HDR_SECOND_RST, MAX_LEN + 8'd1});

    // Random phases, one header setting each
    set_headers(8'h00, 8'hFF);
    run_random(10, 0);

    set_headers(8'hFF, 8'h00);
    send_idle_pct = 61;
    recv_idle_pct = 28;
    run_random(10, 0);

    set_headers(HDR_FIRST_RST, HDR_FIRST_RST);
    run_random(10, 0);

    set_headers(8'($urandom_range(255)), 8'($urandom_range(255)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(10, 24);

    wait_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d bytes under %0d header settings; %0d frames produced replies,",
             sb.bytes_seen, settings_used, sb.frames_replied);
    $display("%0d of %0d predicted replies checked, %0d errors.",
             sb.replies_checked, sb.replies_expected, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### display_reply_frame_parser_unit.f
design/drfp_pkg.sv
design/drfp_front.sv
design/drfp_queue.sv
design/drfp_back.sv
design/display_reply_frame_parser_unit.sv
tb/drfp_tb_pkg.sv
tb/tb_top.sv
